/* design/crf_pkg.sv */
// Shared constants, codes and types of the compaction record filter.
`timescale 1ns / 1ps

package crf_pkg;

  // Default table depths.
  localparam int unsigned DROP_DEPTH_DEF = 256;
  localparam int unsigned TTL_DEPTH_DEF  = 256;

  // Field widths.
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 64;
  localparam int unsigned FAM_W     = 32;
  localparam int unsigned IDX_W     = 32;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned CNT_W     = 64;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_FILTER    = 2'd0;
  localparam logic [1:0] OP_LOAD_DROP = 2'd1;
  localparam logic [1:0] OP_LOAD_TTL  = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  // Decision codes of a result beat.
  localparam logic [1:0] DEC_KEEP    = 2'd0;
  localparam logic [1:0] DEC_DROPPED = 2'd1;
  localparam logic [1:0] DEC_EXPIRED = 2'd2;

  // Status codes of a result beat.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FAMILY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER   = 8'd3;

  // Answer of the search unit; valid while done is high.
  typedef struct packed {
    logic              done;
    logic              found;
    logic [KEY_W-1:0]  payload;
  } lookup_rsp_t;

  // Address width of a table of the given depth.
  function automatic int unsigned addr_w(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width of a counter that can hold the depth itself.
  function automatic int unsigned count_w(int unsigned depth);
    return $clog2(depth + 1);
  endfunction

endpackage

/* design/crf_table.sv */
// Single-port-write, registered-read table memory for sorted keys.
`timescale 1ns / 1ps

module crf_table #(
  parameter int unsigned DEPTH = crf_pkg::DROP_DEPTH_DEF,
  parameter int unsigned WIDTH = crf_pkg::KEY_W
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [crf_pkg::addr_w(DEPTH)-1:0]     waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [crf_pkg::addr_w(DEPTH)-1:0]     raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/crf_lookup.sv */
// Binary search sequencer around one shared 64-bit key comparator.
`timescale 1ns / 1ps

module crf_lookup #(
  parameter int unsigned MAX_DEPTH = crf_pkg::DROP_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [crf_pkg::count_w(MAX_DEPTH)-1:0] count_i,
  input  logic [crf_pkg::KEY_W-1:0]              key_i,
  output logic                                   rd_en_o,
  output logic [crf_pkg::addr_w(MAX_DEPTH)-1:0]  rd_addr_o,
  input  logic [crf_pkg::KEY_W-1:0]              rd_key_i,
  input  logic [crf_pkg::KEY_W-1:0]              rd_pay_i,
  output crf_pkg::lookup_rsp_t                   rsp_o
);

  localparam int unsigned CW = crf_pkg::count_w(MAX_DEPTH);
  localparam int unsigned AW = crf_pkg::addr_w(MAX_DEPTH);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_READ = 4'b0010,
    L_CMP  = 4'b0100,
    L_DONE = 4'b1000
  } lstate_e;

  lstate_e                   state_q, state_d;
  logic [CW-1:0]             lo_q, lo_d;
  logic [CW-1:0]             hi_q, hi_d;
  logic [CW-1:0]             n_q, n_d;
  logic [CW-1:0]             mid_q, mid_d;
  logic [CW-1:0]             mid;
  logic [crf_pkg::KEY_W-1:0] key_q, key_d;
  logic [crf_pkg::KEY_W-1:0] ge_key_q, ge_key_d;
  logic [crf_pkg::KEY_W-1:0] ge_pay_q, ge_pay_d;

  // Probe point halfway between the bounds.
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_addr_o = mid[AW-1:0];

  // One probe is a read state followed by a compare state. The last probe that
  // moved the upper bound holds the entry at the final position.
  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    n_d      = n_q;
    mid_d    = mid_q;
    key_d    = key_q;
    ge_key_d = ge_key_q;
    ge_pay_d = ge_pay_q;
    rd_en_o  = 1'b0;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          lo_d    = '0;
          hi_d    = count_i;
          n_d     = count_i;
          key_d   = key_i;
          state_d = (count_i != '0) ? L_READ : L_DONE;
        end
      end
      L_READ: begin
        rd_en_o = 1'b1;
        mid_d   = mid;
        state_d = L_CMP;
      end
      L_CMP: begin
        if (rd_key_i < key_q) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d     = mid_q;
          ge_key_d = rd_key_i;
          ge_pay_d = rd_pay_i;
        end
        state_d = (lo_d < hi_d) ? L_READ : L_DONE;
      end
      L_DONE: begin
        state_d = L_IDLE;
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search bounds and the captured entry.
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    n_q      <= n_d;
    mid_q    <= mid_d;
    key_q    <= key_d;
    ge_key_q <= ge_key_d;
    ge_pay_q <= ge_pay_d;
  end

  // A hit needs a position inside the table whose key equals the target.
  assign rsp_o.done    = (state_q == L_DONE);
  assign rsp_o.found   = (hi_q != n_q) && (ge_key_q == key_q);
  assign rsp_o.payload = ge_pay_q;

endmodule

/* design/compaction_record_filter_unit.sv */
// Top level of the compaction record filter: control, tables and result register.
`timescale 1ns / 1ps

// Compaction record filter.
// The input channel (in_valid_i / in_stall_o) carries one beat per operation:
// filter a record, load a drop-table entry, load a TTL-table entry or clear
// both tables. Every input beat yields exactly one result beat on the output
// channel (out_valid_o / out_stall_i) with the decision, a status code and the
// running removal counts. The configuration channel (cfg_valid_i /
// cfg_ready_o) writes family, snapshot time, pause and worker mode by index;
// it is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. One item is handled at a time and
// in_stall_o stays high until its result is in the output register; the next
// beat can be taken as soon as it is there. Loads, clears and non-plain
// records go from acceptance straight to the emit state; a record whose key
// hits the cache passes the decide state first. A cache miss binary-searches
// the drop table and, if the key is not found there, the TTL table through
// one shared comparator; each probe is a read state followed by a compare
// state. A stalled result holds the output register; the next item may be
// accepted but its result waits until the held beat is taken. Reset empties
// both tables, clears the cache, the counters and the configuration
// registers.

module compaction_record_filter_unit #(
  parameter int unsigned DROP_DEPTH = crf_pkg::DROP_DEPTH_DEF,
  parameter int unsigned TTL_DEPTH  = crf_pkg::TTL_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [crf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [crf_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [crf_pkg::FAM_W-1:0]     entry_family_i,
  input  logic [crf_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [crf_pkg::TIME_W-1:0]    entry_duration_i,
  input  logic [crf_pkg::IDX_W-1:0]     key_index_i,
  input  logic                          value_is_plain_i,
  input  logic                          value_short_i,
  input  logic [crf_pkg::TIME_W-1:0]    value_stamp_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    decision_o,
  output logic [1:0]                    status_o,
  output logic [crf_pkg::CNT_W-1:0]     removed_dropped_o,
  output logic [crf_pkg::CNT_W-1:0]     removed_expired_o
);

  localparam int unsigned KW   = crf_pkg::KEY_W;
  localparam int unsigned TW   = crf_pkg::TIME_W;
  localparam int unsigned NW   = crf_pkg::CNT_W;
  localparam int unsigned DAW  = crf_pkg::addr_w(DROP_DEPTH);
  localparam int unsigned TAW  = crf_pkg::addr_w(TTL_DEPTH);
  localparam int unsigned DCW  = crf_pkg::count_w(DROP_DEPTH);
  localparam int unsigned TCW  = crf_pkg::count_w(TTL_DEPTH);
  localparam int unsigned MAXD = (DROP_DEPTH > TTL_DEPTH) ? DROP_DEPTH : TTL_DEPTH;
  localparam int unsigned LCW  = crf_pkg::count_w(MAXD);
  localparam int unsigned LAW  = crf_pkg::addr_w(MAXD);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DSTART = 7'b0000010,
    S_DWAIT  = 7'b0000100,
    S_TSTART = 7'b0001000,
    S_TWAIT  = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e                    state_q, state_d;

  // Configuration registers.
  logic [crf_pkg::FAM_W-1:0] family_q;
  logic [TW-1:0]             snapshot_q;
  logic                      paused_q;
  logic                      worker_q;

  // Captured record.
  logic [KW-1:0]             rec_key_q, rec_key_d;
  logic                      short_q, short_d;
  logic [TW-1:0]             stamp_q, stamp_d;
  logic [1:0]                res_dec_q, res_dec_d;
  logic [1:0]                res_st_q, res_st_d;

  // Table fill and order tracking.
  logic [DCW-1:0]            drop_fill_q, drop_fill_d;
  logic [TCW-1:0]            ttl_fill_q, ttl_fill_d;
  logic [KW-1:0]             last_drop_q, last_drop_d;
  logic [KW-1:0]             last_ttl_q, last_ttl_d;

  // Lookup cache and counters.
  logic [KW-1:0]             cached_key_q, cached_key_d;
  logic                      cached_drop_q, cached_drop_d;
  logic [TW-1:0]             cached_dur_q, cached_dur_d;
  logic [NW-1:0]             dropped_q, dropped_d;
  logic [NW-1:0]             expired_q, expired_d;

  // Output register.
  logic                      out_valid_q, out_valid_d;
  logic [1:0]                out_dec_q, out_dec_d;
  logic [1:0]                out_st_q, out_st_d;
  logic [NW-1:0]             out_drp_q, out_drp_d;
  logic [NW-1:0]             out_exp_q, out_exp_d;

  // Search unit and table ports.
  crf_pkg::lookup_rsp_t      lk_rsp;
  logic                      lk_start;
  logic                      lk_sel_ttl;
  logic [LCW-1:0]            lk_count;
  logic                      lk_rd_en;
  logic [LAW-1:0]            lk_rd_addr;
  logic [KW-1:0]             lk_rd_key;
  logic [KW-1:0]             lk_rd_pay;
  logic [KW-1:0]             drop_rdata;
  logic [KW+TW-1:0]          ttl_rdata;

  logic                      accept;
  logic [KW-1:0]             ekey;
  logic [KW-1:0]             rkey;
  logic                      drop_full, drop_order, drop_we;
  logic                      ttl_full, ttl_order, ttl_we;
  logic                      expiry_paused;
  logic [TW-1:0]             expiry_at;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);

  assign ekey = {entry_family_i, entry_index_i};
  assign rkey = {family_q, key_index_i};

  // Load checks: a full table or a key below the last one rejects the entry.
  assign drop_full  = (drop_fill_q == DCW'(DROP_DEPTH));
  assign drop_order = (drop_fill_q != '0) && (ekey < last_drop_q);
  assign drop_we    = accept && (op_i == crf_pkg::OP_LOAD_DROP) && !drop_full && !drop_order;
  assign ttl_full   = (ttl_fill_q == TCW'(TTL_DEPTH));
  assign ttl_order  = (ttl_fill_q != '0) && (ekey < last_ttl_q);
  assign ttl_we     = accept && (op_i == crf_pkg::OP_LOAD_TTL) && !ttl_full && !ttl_order;

  // Expiry test inputs.
  assign expiry_paused = !worker_q && (paused_q || (snapshot_q == '0));
  assign expiry_at     = stamp_q + cached_dur_q;

  // The search unit serves the drop table first, then, on a drop-table miss, the TTL table.
  assign lk_sel_ttl = (state_q == S_TSTART) || (state_q == S_TWAIT);
  assign lk_start   = (state_q == S_DSTART) || (state_q == S_TSTART);
  assign lk_count   = lk_sel_ttl ? LCW'(ttl_fill_q) : LCW'(drop_fill_q);
  assign lk_rd_key  = lk_sel_ttl ? ttl_rdata[KW+TW-1:TW] : drop_rdata;
  assign lk_rd_pay  = lk_sel_ttl ? ttl_rdata[TW-1:0] : '0;

  crf_lookup #(
    .MAX_DEPTH (MAXD)
  ) u_lookup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (lk_start),
    .count_i   (lk_count),
    .key_i     (rec_key_q),
    .rd_en_o   (lk_rd_en),
    .rd_addr_o (lk_rd_addr),
    .rd_key_i  (lk_rd_key),
    .rd_pay_i  (lk_rd_pay),
    .rsp_o     (lk_rsp)
  );

  crf_table #(
    .DEPTH (DROP_DEPTH),
    .WIDTH (KW)
  ) u_drop_table (
    .clk_i   (clk_i),
    .we_i    (drop_we),
    .waddr_i (drop_fill_q[DAW-1:0]),
    .wdata_i (ekey),
    .re_i    (lk_rd_en && !lk_sel_ttl),
    .raddr_i (lk_rd_addr[DAW-1:0]),
    .rdata_o (drop_rdata)
  );

  crf_table #(
    .DEPTH (TTL_DEPTH),
    .WIDTH (KW + TW)
  ) u_ttl_table (
    .clk_i   (clk_i),
    .we_i    (ttl_we),
    .waddr_i (ttl_fill_q[TAW-1:0]),
    .wdata_i ({ekey, entry_duration_i}),
    .re_i    (lk_rd_en && lk_sel_ttl),
    .raddr_i (lk_rd_addr[TAW-1:0]),
    .rdata_o (ttl_rdata)
  );

  // Sequencer: take a beat, for a plain record search on a cache miss and decide, then emit.
  always_comb begin
    state_d       = state_q;
    rec_key_d     = rec_key_q;
    short_d       = short_q;
    stamp_d       = stamp_q;
    res_dec_d     = res_dec_q;
    res_st_d      = res_st_q;
    drop_fill_d   = drop_fill_q;
    ttl_fill_d    = ttl_fill_q;
    last_drop_d   = last_drop_q;
    last_ttl_d    = last_ttl_q;
    cached_key_d  = cached_key_q;
    cached_drop_d = cached_drop_q;
    cached_dur_d  = cached_dur_q;
    dropped_d     = dropped_q;
    expired_d     = expired_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_dec_d     = out_dec_q;
    out_st_d      = out_st_q;
    out_drp_d     = out_drp_q;
    out_exp_d     = out_exp_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rec_key_d = rkey;
          short_d   = value_short_i;
          stamp_d   = value_stamp_i;
          res_dec_d = crf_pkg::DEC_KEEP;
          res_st_d  = crf_pkg::ST_OK;
          state_d   = S_EMIT;
          case (op_i)
            crf_pkg::OP_LOAD_DROP: begin
              if (drop_full) begin
                res_st_d = crf_pkg::ST_FULL;
              end else if (drop_order) begin
                res_st_d = crf_pkg::ST_ORDER;
              end else begin
                drop_fill_d   = drop_fill_q + DCW'(1);
                last_drop_d   = ekey;
                cached_key_d  = '0;
                cached_drop_d = 1'b0;
                cached_dur_d  = '0;
              end
            end
            crf_pkg::OP_LOAD_TTL: begin
              if (ttl_full) begin
                res_st_d = crf_pkg::ST_FULL;
              end else if (ttl_order) begin
                res_st_d = crf_pkg::ST_ORDER;
              end else begin
                ttl_fill_d    = ttl_fill_q + TCW'(1);
                last_ttl_d    = ekey;
                cached_key_d  = '0;
                cached_drop_d = 1'b0;
                cached_dur_d  = '0;
              end
            end
            crf_pkg::OP_CLEAR: begin
              drop_fill_d   = '0;
              ttl_fill_d    = '0;
              cached_key_d  = '0;
              cached_drop_d = 1'b0;
              cached_dur_d  = '0;
            end
            crf_pkg::OP_FILTER: begin
              if (value_is_plain_i) begin
                state_d = (rkey == cached_key_q) ? S_DECIDE : S_DSTART;
              end
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_DSTART: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (lk_rsp.done) begin
          cached_key_d  = rec_key_q;
          cached_drop_d = lk_rsp.found;
          state_d       = lk_rsp.found ? S_DECIDE : S_TSTART;
        end
      end
      S_TSTART: begin
        state_d = S_TWAIT;
      end
      S_TWAIT: begin
        if (lk_rsp.done) begin
          cached_dur_d = lk_rsp.found ? lk_rsp.payload : '0;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (cached_drop_q) begin
          dropped_d = dropped_q + NW'(1);
          res_dec_d = crf_pkg::DEC_DROPPED;
        end else if ((cached_dur_q != '0) && !expiry_paused) begin
          if (short_q) begin
            res_st_d = crf_pkg::ST_SHORT;
          end else if (expiry_at <= snapshot_q) begin
            expired_d = expired_q + NW'(1);
            res_dec_d = crf_pkg::DEC_EXPIRED;
          end
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_dec_d   = res_dec_q;
          out_st_d    = res_st_q;
          out_drp_d   = dropped_q;
          out_exp_d   = expired_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, fills, cache, counters and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      drop_fill_q   <= '0;
      ttl_fill_q    <= '0;
      cached_key_q  <= '0;
      cached_drop_q <= 1'b0;
      cached_dur_q  <= '0;
      dropped_q     <= '0;
      expired_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      drop_fill_q   <= drop_fill_d;
      ttl_fill_q    <= ttl_fill_d;
      cached_key_q  <= cached_key_d;
      cached_drop_q <= cached_drop_d;
      cached_dur_q  <= cached_dur_d;
      dropped_q     <= dropped_d;
      expired_q     <= expired_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rec_key_q   <= rec_key_d;
    short_q     <= short_d;
    stamp_q     <= stamp_d;
    res_dec_q   <= res_dec_d;
    res_st_q    <= res_st_d;
    last_drop_q <= last_drop_d;
    last_ttl_q  <= last_ttl_d;
    out_dec_q   <= out_dec_d;
    out_st_q    <= out_st_d;
    out_drp_q   <= out_drp_d;
    out_exp_q   <= out_exp_d;
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q   <= '0;
      snapshot_q <= '0;
      paused_q   <= 1'b0;
      worker_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        crf_pkg::CFG_FAMILY:   family_q   <= cfg_data_i[crf_pkg::FAM_W-1:0];
        crf_pkg::CFG_SNAPSHOT: snapshot_q <= cfg_data_i[TW-1:0];
        crf_pkg::CFG_PAUSED:   paused_q   <= cfg_data_i[0];
        crf_pkg::CFG_WORKER:   worker_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign decision_o        = out_dec_q;
  assign status_o          = out_st_q;
  assign removed_dropped_o = out_drp_q;
  assign removed_expired_o = out_exp_q;

endmodule

/* design/crf_checker.sv */
// Port-level checks of the compaction record filter, bound to the top level.
`timescale 1ns / 1ps

module crf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [1:0]                decision_o,
  input logic [1:0]                status_o,
  input logic [crf_pkg::CNT_W-1:0] removed_dropped_o,
  input logic [crf_pkg::CNT_W-1:0] removed_expired_o
);

  // One item at a time: an accepted beat stalls the input on the next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // A stalled result beat holds its valid and its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(decision_o) &&
    $stable(status_o) && $stable(removed_dropped_o) && $stable(removed_expired_o))
    else $error("stalled result beat changed");

  // A removal always comes with status ok, and the decision code is defined.
  a_decision_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (decision_o == crf_pkg::DEC_KEEP || status_o == crf_pkg::ST_OK) &&
    (decision_o == crf_pkg::DEC_KEEP || decision_o == crf_pkg::DEC_DROPPED ||
     decision_o == crf_pkg::DEC_EXPIRED))
    else $error("bad decision or status on a result beat");

  // The configuration port never back-pressures.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind compaction_record_filter_unit crf_checker u_crf_checker (.*);
